/* rtl/core/sliding_window_throughput_meter_top_assert.svh */
// ----------------------------------------------------------------------------
// sliding window throughput meter assertion macros
// shared property shapes, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_THROUGHPUT_METER_TOP_ASSERT_SVH
`define SLIDING_WINDOW_THROUGHPUT_METER_TOP_ASSERT_SVH

// same-cycle implication
`define SWTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/swtm_pkg.sv */
// ----------------------------------------------------------------------------
// swtm_pkg
// shared types and constants of the sliding window throughput meter
// ----------------------------------------------------------------------------
package swtm_pkg;

  localparam int DATA_W     = 48;
  localparam int ACT_W      = 3;
  localparam int CFG_W      = 16;
  localparam int PROD_W     = 58;  // 48-bit gain times 1000
  localparam int DCNT_W     = $clog2(PROD_W);
  localparam int WINDOW_DEF = 8;

  localparam logic [CFG_W-1:0]  MIN_INTERVAL_RST = 16'd900;
  localparam logic [9:0]        SPEED_SCALE      = 10'd1000;
  localparam logic [DATA_W-1:0] MAX_SPEED        = {DATA_W{1'b1}};

  // event codes
  localparam logic [ACT_W-1:0] ACT_TICK     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PROGRESS = 3'd2;
  localparam logic [ACT_W-1:0] ACT_OFFSET   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FINISH   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PEER     = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RESUME   = 3'd6;

  typedef struct packed {
    logic cap;       // capture input transaction
    logic apply;     // execute non-tick event
    logic elapsed;   // elapsed time and current bytes
    logic check;     // distance to last sample
    logic commit;    // take the sample into the window
    logic rd;        // read oldest sample
    logic prep;      // gain, span and zero test
    logic mul;       // scale gain, init divider
    logic div_step;  // one quotient bit
    logic fin;       // saturate, restart window on zero
    logic load_out;  // fill output register
  } swtm_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             ok1;
    logic             ok2;
    logic             zero;
    logic             div_last;
    logic             out_free;
  } swtm_stat_t;

endpackage

/* rtl/core/swtm_ctrl.sv */
// ----------------------------------------------------------------------------
// swtm_ctrl
// sequencer for one event at a time: decode, sample checks, divide, emit
// ----------------------------------------------------------------------------
module swtm_ctrl
  import swtm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  swtm_stat_t stat,
  output swtm_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_CHECK2 = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_PREP   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.action == ACT_TICK) begin
          cmd.elapsed = 1'b1;
          state_nxt   = S_CHECK;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = (stat.action == ACT_PEER) ? S_EMIT : S_IDLE;
        end
      end
      S_CHECK: begin
        if (stat.ok1) begin
          cmd.check = 1'b1;
          state_nxt = S_CHECK2;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CHECK2: begin
        if (stat.ok2) begin
          cmd.commit = 1'b1;
          state_nxt  = S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (stat.zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* rtl/core/swtm_dp.sv */
// ----------------------------------------------------------------------------
// swtm_dp
// meter state, circular sample window, restoring divider, output register
// ----------------------------------------------------------------------------
module swtm_dp
  import swtm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swtm_cmd_t             cmd,
  output swtm_stat_t            stat,
  input  logic [2*DATA_W-1:0]   in_tdata,
  input  logic [ACT_W-1:0]      in_tuser,
  input  logic                  cfg_valid,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,
  output logic                  out_tuser
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  // captured transaction
  logic [ACT_W-1:0]  action_r;
  logic [DATA_W-1:0] now_r, value_r;

  // meter state
  logic              running_r;
  logic [DATA_W-1:0] start_r, last_r, bytes_r, base_r;
  logic [CFG_W-1:0]  min_r;
  logic [IDX_W-1:0]  head_r, newest_r;
  logic [CNT_W-1:0]  cnt_r;

  // sample store {bytes, time}
  logic [2*DATA_W-1:0] sample_mem [WINDOW];
  logic [2*DATA_W-1:0] old_r;

  // work registers
  logic [DATA_W-1:0] elapsed_r, cur_r, diff_r, gain_r, span_r, rem_r, speed_r;
  logic              ok1_r, ge_r, zero_r;
  logic [PROD_W-1:0] dq_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              out_valid_r, out_peer_r;
  logic [DATA_W-1:0] out_data_r;

  // window bookkeeping for a new sample
  logic              full;
  logic [IDX_W-1:0]  head_adv, wr_idx;
  logic [CNT_W-1:0]  cnt_eff;
  logic [IDX_W:0]    wr_sum;

  always_comb begin
    full     = (cnt_r >= CNT_W'(WINDOW));
    head_adv = head_r;
    if (full) head_adv = (head_r == IDX_W'(WINDOW - 1)) ? '0 : head_r + 1'b1;
    cnt_eff  = full ? CNT_W'(WINDOW - 1) : cnt_r;
    wr_sum   = (IDX_W+1)'(head_adv) + (IDX_W+1)'(cnt_eff);
    if (wr_sum >= (IDX_W+1)'(WINDOW)) wr_sum = wr_sum - (IDX_W+1)'(WINDOW);
    wr_idx   = wr_sum[IDX_W-1:0];
  end

  // divider step
  logic [DATA_W:0]   trial;
  logic              q_bit;
  logic [DATA_W:0]   trial_sub;

  always_comb begin
    trial     = {rem_r, dq_r[PROD_W-1]};
    q_bit     = (trial >= {1'b0, span_r});
    trial_sub = trial - {1'b0, span_r};
  end

  // final speed
  logic [DATA_W-1:0] spd;
  always_comb begin
    if (zero_r)                           spd = '0;
    else if (dq_r > PROD_W'(MAX_SPEED))   spd = MAX_SPEED;
    else                                  spd = dq_r[DATA_W-1:0];
  end

  assign stat.action   = action_r;
  assign stat.ok1      = ok1_r;
  assign stat.ok2      = ge_r && (diff_r >= DATA_W'(min_r));
  assign stat.zero     = zero_r;
  assign stat.div_last = (dcnt_r == DCNT_W'(PROD_W - 1));
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_peer_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      start_r     <= '0;
      last_r      <= '0;
      bytes_r     <= '0;
      base_r      <= '0;
      min_r       <= MIN_INTERVAL_RST;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) min_r <= cfg_data;
      if (cmd.apply) begin
        case (action_r)
          ACT_START: begin
            start_r   <= now_r;
            last_r    <= '0;
            bytes_r   <= base_r;
            head_r    <= '0;
            cnt_r     <= CNT_W'(1);
            running_r <= 1'b1;
          end
          ACT_PROGRESS: bytes_r <= value_r;
          ACT_OFFSET:   base_r  <= value_r;
          ACT_FINISH: begin
            base_r    <= '0;
            running_r <= 1'b0;
          end
          ACT_PEER:     running_r <= 1'b0;
          ACT_RESUME:   bytes_r <= base_r;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        last_r <= elapsed_r;
        head_r <= head_adv;
        cnt_r  <= cnt_eff + 1'b1;
      end
      if (cmd.fin && (spd == '0)) begin
        // zero speed: window restarts at the newest sample
        head_r <= newest_r;
        cnt_r  <= CNT_W'(1);
      end
      if (cmd.load_out)  out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (cmd.apply && (action_r == ACT_START)) sample_mem[0] <= '0;
    else if (cmd.commit) sample_mem[wr_idx] <= {cur_r, elapsed_r};
    if (cmd.rd) old_r <= sample_mem[head_r];
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      action_r <= in_tuser;
      now_r    <= in_tdata[DATA_W-1:0];
      value_r  <= in_tdata[2*DATA_W-1:DATA_W];
    end
    if (cmd.elapsed) begin
      elapsed_r <= now_r - start_r;
      ok1_r     <= running_r && (now_r >= start_r);
      cur_r     <= (bytes_r >= base_r) ? bytes_r - base_r : '0;
    end
    if (cmd.check) begin
      diff_r <= elapsed_r - last_r;
      ge_r   <= (elapsed_r >= last_r);
    end
    if (cmd.commit) newest_r <= wr_idx;
    if (cmd.prep) begin
      zero_r <= (cur_r < old_r[2*DATA_W-1:DATA_W]) || (elapsed_r <= old_r[DATA_W-1:0]);
      gain_r <= cur_r - old_r[2*DATA_W-1:DATA_W];
      span_r <= elapsed_r - old_r[DATA_W-1:0];
    end
    if (cmd.mul) begin
      dq_r   <= PROD_W'(gain_r) * PROD_W'(SPEED_SCALE);
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dq_r   <= {dq_r[PROD_W-2:0], q_bit};
      rem_r  <= q_bit ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.fin) speed_r <= spd;
    if (cmd.load_out) begin
      out_peer_r <= (action_r == ACT_PEER);
      out_data_r <= (action_r == ACT_PEER) ? value_r : speed_r;
    end
  end

`include "sliding_window_throughput_meter_top_assert.svh"

  `SWTM_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(WINDOW), "sample count beyond window")
  `SWTM_ASSERT_NOW(a_head_range, 1'b1, head_r <= IDX_W'(WINDOW - 1), "head out of range")
  `SWTM_ASSERT_NOW(a_run_cnt, running_r, cnt_r != '0, "running with empty window")
  `SWTM_ASSERT_NEXT(a_commit_two, cmd.commit, cnt_r >= CNT_W'(2), "commit left under two samples")

endmodule

/* rtl/core/sliding_window_throughput_meter_top.sv */
// result: a sampling tick that takes a sample produces its speed through the 58-step bit-serial
//   divider, which a zero window test skips; a peer event emits its speed without the divider
// throughput: one event at a time; the next event is accepted only once the current one is
//   through, including the emit of its result, which waits for a free output register
// reset: synchronous active-low rst_n clears state; the sample store is not cleared
// ----------------------------------------------------------------------------
// sliding_window_throughput_meter_top
// transfer speed over a sliding window of time/byte samples, in bytes per second
// ----------------------------------------------------------------------------
module sliding_window_throughput_meter_top
  import swtm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF  // samples held in the window, 2 to 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // input events
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2*DATA_W-1:0] in_tdata,   // [47:0] now_ms, [95:48] value
  input  logic [ACT_W-1:0]    in_tuser,   // [2:0] action
  // min_interval_ms register write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  // results
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DATA_W-1:0]   out_tdata,  // [47:0] speed
  output logic                out_tuser   // [0] speed_from_peer
);

  swtm_cmd_t  cmd;
  swtm_stat_t stat;

  // register writes are always accepted and land in the next cycle
  assign cfg_ready = 1'b1;

  // sequencer: one transaction in flight, output register decouples the result side
  swtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: state registers, circular window store, divider, output stage
  swtm_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* test/throughput_meter_checker.sv */
// ----------------------------------------------------------------------------
// throughput_meter_checker
// watches the event, register and speed channels of the throughput meter,
// keeps its own copy of the sliding window and checks every speed report
// ----------------------------------------------------------------------------
module throughput_meter_checker
  import swtm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [2*DATA_W-1:0] in_tdata,   // [47:0] now_ms, [95:48] value
  input  logic [ACT_W-1:0]    in_tuser,   // [2:0] action
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [DATA_W-1:0]   out_tdata,  // [47:0] speed
  input  logic                out_tuser,  // [0] speed_from_peer
  output int                  mismatches,
  output int                  speeds_pending
);

  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic [DATA_W-1:0] speed;
    logic              from_peer;
  } speed_report_t;

  speed_report_t     speeds_due[$];
  int                fail_count;
  int                due_count;

  // mirrored meter state
  logic [CFG_W-1:0]  min_gap;
  logic              metering;
  logic [DATA_W-1:0] t_start;
  logic [DATA_W-1:0] t_last;
  int                n_samples;
  logic [DATA_W-1:0] win_t [WINDOW_DEF];
  logic [DATA_W-1:0] win_b [WINDOW_DEF];
  logic [DATA_W-1:0] bytes_seen;
  logic [DATA_W-1:0] offset;

  assign mismatches     = fail_count;
  assign speeds_pending = due_count;

  function automatic logic [DATA_W-1:0] net_bytes();
    return (bytes_seen >= offset) ? bytes_seen - offset : '0;
  endfunction

  // 1000 * gain / span over the window, zero when the window shrinks or has no span
  function automatic logic [DATA_W-1:0] window_rate();
    logic [DATA_W-1:0] gain;
    logic [DATA_W-1:0] span;
    logic [63:0]       scaled;
    int                newest;
    newest = n_samples - 1;
    if (win_b[newest] < win_b[0] || win_t[newest] <= win_t[0]) return '0;
    gain   = win_b[newest] - win_b[0];
    span   = win_t[newest] - win_t[0];
    scaled = (64'(gain) * 64'd1000) / 64'(span);
    if (scaled > 64'(MAX_SPEED)) return MAX_SPEED;
    return scaled[DATA_W-1:0];
  endfunction

  function automatic bit take_sample(input logic [DATA_W-1:0] now, output speed_report_t rep);
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] rate;
    rep = '0;
    if (!metering || now < t_start) return 1'b0;
    elapsed = now - t_start;
    if (elapsed < t_last || elapsed - t_last < min_gap) return 1'b0;
    t_last = elapsed;
    if (n_samples >= WINDOW_DEF) begin
      for (int i = 1; i < WINDOW_DEF; i++) begin
        win_t[i-1] = win_t[i];
        win_b[i-1] = win_b[i];
      end
      n_samples = WINDOW_DEF - 1;
    end
    cur              = net_bytes();
    win_t[n_samples] = elapsed;
    win_b[n_samples] = cur;
    n_samples++;
    rate = window_rate();
    if (rate == '0) begin
      n_samples = 1;
      win_t[0]  = elapsed;
      win_b[0]  = cur;
    end
    rep.speed     = rate;
    rep.from_peer = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit meter_event(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] now,
                                     input logic [DATA_W-1:0] val, output speed_report_t rep);
    rep = '0;
    case (act)
      ACT_TICK: begin
        return take_sample(now, rep);
      end
      ACT_START: begin
        t_start    = now;
        t_last     = '0;
        bytes_seen = offset;
        win_t[0]   = '0;
        win_b[0]   = '0;
        n_samples  = 1;
        metering   = 1'b1;
      end
      ACT_PROGRESS: bytes_seen = val;
      ACT_OFFSET:   offset = val;
      ACT_FINISH: begin
        offset   = '0;
        metering = 1'b0;
      end
      ACT_PEER: begin
        metering      = 1'b0;
        rep.speed     = val;
        rep.from_peer = 1'b1;
        return 1'b1;
      end
      ACT_RESUME:   bytes_seen = offset;
      default: ;
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk) begin : monitor
    speed_report_t want;
    speed_report_t got;
    if (!rst_n) begin
      speeds_due.delete();
      fail_count = 0;
      min_gap    = MIN_INTERVAL_RST;
      metering   = 1'b0;
      t_start    = '0;
      t_last     = '0;
      n_samples  = 0;
      bytes_seen = '0;
      offset     = '0;
      for (int i = 0; i < WINDOW_DEF; i++) begin
        win_t[i] = '0;
        win_b[i] = '0;
      end
    end else begin
      // a result can only belong to an earlier transaction, so check it first
      if (out_tvalid && out_tready) begin
        got.speed     = out_tdata;
        got.from_peer = out_tuser;
        if (speeds_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected speed report: expected none, actual speed %0d peer %0b",
                     $time, got.speed, got.from_peer);
        end else begin
          want = speeds_due.pop_front();
          if (got.speed !== want.speed) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: speed mismatch: expected %0d, actual %0d",
                       $time, want.speed, got.speed);
          end
          if (got.from_peer !== want.from_peer) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: speed_from_peer mismatch: expected %0b, actual %0b",
                       $time, want.from_peer, got.from_peer);
          end
        end
      end
      if (cfg_valid && cfg_ready) min_gap = cfg_data;
      if (in_tvalid && in_tready) begin
        if (meter_event(in_tuser, in_tdata[DATA_W-1:0], in_tdata[2*DATA_W-1:DATA_W], want))
          speeds_due.push_back(want);
      end
    end
    due_count = speeds_due.size();
  end

endmodule

/* test/sliding_window_throughput_meter_top_test.sv */
// ----------------------------------------------------------------------------
// sliding_window_throughput_meter_top_test
// drives directed and random event streams into the throughput meter under
// several minimum sample intervals, with random idle bursts on both channels
// and one long result hold-off; the checker beside the block judges results
// ----------------------------------------------------------------------------
module sliding_window_throughput_meter_top_test;
  import swtm_pkg::*;

  localparam int              CYCLE_LIMIT     = 400000;
  localparam int              RANDOM_EVENTS   = 550;
  localparam int              PHASES          = 6;
  localparam int              PRESSURE_CYCLES = 400;  // long result hold-off
  localparam int              QUIET_CYCLES    = 100;  // covers a sampling tick's run through the divider
  localparam logic [ACT_W-1:0] ACT_UNUSED     = 3'd7;  // spare code, the block ignores it

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [2*DATA_W-1:0] in_tdata   = '0;  // [47:0] now_ms, [95:48] value
  logic [ACT_W-1:0]    in_tuser   = '0;  // [2:0] action
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;        // [47:0] speed
  logic                out_tuser;        // [0] speed_from_peer

  int                  mismatches;
  int                  speeds_pending;
  int                  cycle_count = 0;
  int                  events_sent = 0;
  int                  hold_asked  = 0;   // long hold-offs requested from the result side
  bit                  idle_on     = 1'b0; // random idle bursts enabled on both sides
  logic [CFG_W-1:0]    interval_now = MIN_INTERVAL_RST;
  logic [DATA_W-1:0]   offset_now   = '0;  // base offset as the stimulus believes it

  sliding_window_throughput_meter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  throughput_meter_checker i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatches     (mismatches),
    .speeds_pending (speeds_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_window_throughput_meter_top regression: fail");
      $finish;
    end
  end

  // result side: ready by default, random stall bursts while idling is on,
  // and one long hold-off on request so the meter backs up into its input
  initial begin : result_sink
    int stall_left;
    int holds_served;
    stall_left   = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_asked > holds_served) begin
        holds_served++;
        stall_left = PRESSURE_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand48();
    return DATA_W'({$urandom, $urandom});
  endfunction

  // one event transaction; entered and left at a falling edge, valid stays
  // high into the next event unless an idle burst comes first
  task automatic send_event(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] now,
                            input logic [DATA_W-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, now};
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    events_sent++;
    @(negedge clk);
  endtask

  // stop offering events and let every pending speed come out, then give the
  // meter time to finish an event that has no result
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (speeds_pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_interval(input logic [CFG_W-1:0] ms);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid    <= 1'b0;
    interval_now = ms;
  endtask

  // a transfer: optional offset, start, then ticks and progress with random
  // content, a few broken pieces, and an optional finish or peer report
  task automatic run_session();
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] gap;
    int                steps;
    int                pick;
    case ($urandom_range(0, 3))
      0:       t = DATA_W'($urandom_range(0, 1000));
      1:       t = DATA_W'($urandom);
      2:       t = rand48();
      default: t = MAX_SPEED - DATA_W'($urandom_range(0, 4 * interval_now)); // time wraps
    endcase
    if ($urandom_range(0, 2) == 0) begin
      offset_now = ($urandom_range(0, 1) == 0) ? DATA_W'($urandom_range(0, 1 << 16)) : rand48();
      send_event(ACT_OFFSET, rand48(), offset_now);
    end
    send_event(ACT_START, t, rand48());
    b     = offset_now;
    steps = $urandom_range(4, 24);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 6))
          0:       gap = DATA_W'(interval_now) - 1;  // one short of the interval
          1:       gap = DATA_W'(interval_now);
          2:       gap = DATA_W'(interval_now) + DATA_W'($urandom_range(0, 3 * interval_now));
          3:       gap = DATA_W'(interval_now) + DATA_W'($urandom_range(0, 50));
          4:       gap = DATA_W'($urandom);
          default: gap = DATA_W'(interval_now) + DATA_W'($urandom_range(0, 2000));
        endcase
        if ($urandom_range(0, 9) == 0) begin
          // clock going backwards, the session time stays put
          send_event(ACT_TICK, t - DATA_W'($urandom_range(1, 2 * interval_now)), rand48());
        end else begin
          t = t + gap;
          send_event(ACT_TICK, t, rand48());
        end
      end else if (pick < 80) begin
        case ($urandom_range(0, 5))
          0:       ;                                          // no progress
          1, 2:    b = b + DATA_W'($urandom_range(0, 1 << 20));
          3:       b = b + (rand48() >> $urandom_range(0, 20));
          4:       b = b - DATA_W'($urandom_range(0, 1 << 16)); // progress going back
          default: b = rand48();
        endcase
        send_event(ACT_PROGRESS, rand48(), b);
      end else if (pick < 86) begin
        b = offset_now;
        send_event(ACT_RESUME, rand48(), rand48());
      end else if (pick < 92) begin
        offset_now = ($urandom_range(0, 1) == 0) ? b - DATA_W'($urandom_range(0, 1 << 12))
                                                 : rand48();
        send_event(ACT_OFFSET, rand48(), offset_now);
      end else begin
        // noise: any code, any fields
        send_event(ACT_W'($urandom_range(0, 7)), rand48(), rand48());
      end
    end
    case ($urandom_range(0, 3))
      0: begin
        offset_now = '0;
        send_event(ACT_FINISH, rand48(), rand48());
      end
      1:       send_event(ACT_PEER, rand48(), rand48());
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] interval_plan [PHASES];
    int               directed_count;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under the reset interval of 900 ms
    send_event(ACT_TICK,     48'd1000,  '0);        // tick while stopped
    send_event(ACT_UNUSED,   MAX_SPEED, MAX_SPEED); // spare code, all field bits high
    send_event(ACT_PEER,     '0,        '0);        // peer report of zero
    send_event(ACT_OFFSET,   '0,        48'd100);
    send_event(ACT_START,    48'd5000,  MAX_SPEED);
    send_event(ACT_PROGRESS, '0,        48'd100100);
    send_event(ACT_TICK,     48'd5899,  '0);        // one short of the interval
    send_event(ACT_TICK,     48'd5900,  '0);        // first real sample
    send_event(ACT_TICK,     48'd4999,  '0);        // time before start
    send_event(ACT_PROGRESS, '0,        MAX_SPEED);
    send_event(ACT_TICK,     48'd6800,  '0);        // large speed, below saturation
    send_event(ACT_PROGRESS, '0,        48'd50);    // below the offset
    send_event(ACT_TICK,     48'd7700,  '0);        // zero speed, window restarts
    send_event(ACT_TICK,     48'd6000,  '0);        // time going backwards
    send_event(ACT_RESUME,   '0,        '0);
    send_event(ACT_OFFSET,   '0,        '0);
    send_event(ACT_PROGRESS, '0,        48'd5000);
    send_event(ACT_TICK,     48'd8600,  '0);
    send_event(ACT_TICK,     MAX_SPEED, '0);        // huge span, speed rounds to zero
    send_event(ACT_FINISH,   '0,        '0);
    send_event(ACT_TICK,     48'd20000, '0);        // stopped by finish
    send_event(ACT_START,    '0,        '0);
    send_event(ACT_PROGRESS, '0,        MAX_SPEED);
    send_event(ACT_TICK,     48'd900,   '0);
    send_event(ACT_PEER,     '0,        MAX_SPEED); // largest peer report
    directed_count = events_sent;

    // interval settings per phase, extremes among them
    interval_plan[0] = 16'd1;
    interval_plan[1] = 16'hFFFF;
    interval_plan[2] = CFG_W'($urandom_range(2, 5000));
    interval_plan[3] = 16'd2;
    interval_plan[4] = CFG_W'($urandom_range(1, 65535));
    interval_plan[5] = MIN_INTERVAL_RST;

    for (int phase = 0; phase < PHASES; phase++) begin
      write_interval(interval_plan[phase]);
      if (phase == 0) begin
        // long result hold-off with the sender pushing flat out
        idle_on = 1'b0;
        hold_asked++;
        run_session();
      end
      while (events_sent < directed_count + (phase + 1) * RANDOM_EVENTS / PHASES) begin
        // the last phase runs without idling, earlier ones mix both
        idle_on = (phase != PHASES - 1) && ($urandom_range(0, 2) != 0);
        run_session();
      end
    end

    idle_on = 1'b0;
    wait_quiet();
    if (mismatches == 0 && speeds_pending == 0) begin
      $display("sliding_window_throughput_meter_top regression: pass");
    end else begin
      $display("sliding_window_throughput_meter_top regression: fail");
    end
    $finish;
  end

endmodule

/* sliding_window_throughput_meter_top.f */
+incdir+rtl/core
rtl/core/swtm_pkg.sv
rtl/core/swtm_ctrl.sv
rtl/core/swtm_dp.sv
rtl/core/sliding_window_throughput_meter_top.sv
test/throughput_meter_checker.sv
test/sliding_window_throughput_meter_top_test.sv
